/* src/z80rle_pkg.sv */
package z80rle_pkg;

	// Width of the output limit register and of the produced-byte count.
	localparam int unsigned LIMIT_W = 17;
	localparam logic [LIMIT_W-1:0] MAX_OUTPUT  = LIMIT_W'(65536);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16384);

	localparam logic [7:0] RLE_MARK  = 8'hED;
	localparam logic [7:0] ZERO_BYTE = 8'h00;

	// One byte can cause at most four run descriptors.
	localparam int unsigned RES_MAX = 4;
	localparam int unsigned RIDX_W  = $clog2(RES_MAX);

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		STOP_NONE,
		STOP_MARK,
		STOP_ZERO,
		STOP_FULL
	} stop_t;

	typedef struct packed {
		logic [7:0] value;
		logic [7:0] rep;
	} run_t;

	// All the descriptors that one accepted byte causes.
	typedef struct packed {
		run_t [RES_MAX-1:0] runs;
		logic [RIDX_W-1:0]  last_idx;
		logic               blk_last;
		stop_t              status;
	} pkt_t;

endpackage

/* src/z80rle_front.sv */
module z80rle_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [7:0]                      data_byte,
	input  logic                            block_last,
	input  logic                            byte_valid,
	output logic                            byte_ready,
	input  logic [z80rle_pkg::LIMIT_W-1:0]  limit,
	input  logic                            q_full,
	output logic                            q_push,
	output z80rle_pkg::pkt_t                q_data
);
	import z80rle_pkg::*;

	logic [7:0]         held_q [3];
	logic [1:0]         hcnt_q;
	logic [LIMIT_W-1:0] prod_q;
	stop_t              stop_q;

	logic [LIMIT_W-1:0] eff_lim;
	logic [LIMIT_W:0]   room0;
	logic [LIMIT_W:0]   room_a;
	logic               full0;
	logic [7:0]         w [4];
	logic [7:0]         wb [3];
	logic               decide;
	logic               active;
	logic               accept;
	logic [7:0]         rep_a;
	logic               emit_a;
	run_t               run_a;
	stop_t              st_a;
	stop_t              st_b;
	logic [LIMIT_W-1:0] prod_a;
	logic [2:0]         len_b;
	logic [2:0]         k;
	logic [2:0]         n;
	run_t [RES_MAX-1:0] runs;

	always_comb begin
		eff_lim = (limit > MAX_OUTPUT) ? MAX_OUTPUT : limit;
		// Room left; the top bit flags a limit lowered below the count.
		room0   = {1'b0, eff_lim} - {1'b0, prod_q};
		full0   = room0[LIMIT_W] || (room0 == '0);

		w[0] = (hcnt_q > 2'd0) ? held_q[0] : data_byte;
		w[1] = (hcnt_q > 2'd1) ? held_q[1] : data_byte;
		w[2] = (hcnt_q > 2'd2) ? held_q[2] : data_byte;
		w[3] = data_byte;

		decide = (hcnt_q == 2'd3);
		active = (stop_q == STOP_NONE);
		rep_a  = (room0 < {{(LIMIT_W-7){1'b0}}, w[2]}) ? room0[7:0] : w[2];

		st_a   = stop_q;
		emit_a = 1'b0;
		run_a  = '0;
		prod_a = prod_q;
		room_a = room0;
		wb[0]  = w[0];
		wb[1]  = w[1];
		wb[2]  = w[2];
		len_b  = {1'b0, hcnt_q} + 3'd1;

		if (active && decide) begin
			if (full0) begin
				st_a = STOP_FULL;
			end else if (w[0] == ZERO_BYTE && w[1] == RLE_MARK && w[2] == RLE_MARK
					&& w[3] == ZERO_BYTE) begin
				st_a = STOP_MARK;
			end else if (w[0] == RLE_MARK && w[1] == RLE_MARK) begin
				if (w[2] == ZERO_BYTE) begin
					st_a = STOP_ZERO;
				end else begin
					emit_a      = 1'b1;
					run_a.value = w[3];
					run_a.rep   = rep_a;
					prod_a      = prod_q + LIMIT_W'(rep_a);
					room_a      = room0 - (LIMIT_W+1)'(rep_a);
					len_b       = 3'd0;
					if (room_a == '0) begin
						st_a = STOP_FULL;
					end
				end
			end else begin
				emit_a      = 1'b1;
				run_a.value = w[0];
				run_a.rep   = 8'd1;
				prod_a      = prod_q + LIMIT_W'(1);
				room_a      = room0 - (LIMIT_W+1)'(1);
				wb[0]       = w[1];
				wb[1]       = w[2];
				wb[2]       = w[3];
				len_b       = 3'd3;
				if (room_a == '0) begin
					st_a = STOP_FULL;
				end
			end
		end

		// Flush of the held bytes as literals on the last byte of a block.
		k    = 3'd0;
		st_b = st_a;
		if (active && block_last && st_a == STOP_NONE && len_b != 3'd0) begin
			if (room_a[LIMIT_W]) begin
				st_b = STOP_FULL;
			end else if (room_a < (LIMIT_W+1)'(len_b)) begin
				k    = room_a[2:0];
				st_b = STOP_FULL;
			end else begin
				k = len_b;
				if (room_a == (LIMIT_W+1)'(len_b)) begin
					st_b = STOP_FULL;
				end
			end
		end

		n = {2'b00, emit_a} + k;

		if (emit_a) begin
			runs[0] = run_a;
			runs[1] = '{value: wb[0], rep: 8'd1};
			runs[2] = '{value: wb[1], rep: 8'd1};
			runs[3] = '{value: wb[2], rep: 8'd1};
		end else if (n == 3'd0) begin
			runs    = '0;
		end else begin
			runs[0] = '{value: wb[0], rep: 8'd1};
			runs[1] = '{value: wb[1], rep: 8'd1};
			runs[2] = '{value: wb[2], rep: 8'd1};
			runs[3] = '0;
		end

		q_data.runs     = runs;
		q_data.last_idx = (n == 3'd0) ? '0 : RIDX_W'(n - 3'd1);
		q_data.blk_last = block_last;
		q_data.status   = block_last ? st_b : STOP_NONE;

		byte_ready = !q_full;
		accept     = byte_valid && byte_ready;
		q_push     = accept && (n != 3'd0 || block_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q <= 2'd0;
			prod_q <= '0;
			stop_q <= STOP_NONE;
		end else if (accept) begin
			if (block_last) begin
				hcnt_q <= 2'd0;
				prod_q <= '0;
				stop_q <= STOP_NONE;
			end else if (active) begin
				stop_q <= st_a;
				prod_q <= prod_a;
				hcnt_q <= (st_a == STOP_NONE) ? len_b[1:0] : 2'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && active) begin
			held_q[0] <= wb[0];
			held_q[1] <= wb[1];
			held_q[2] <= wb[2];
		end
	end

	a_stop_empties_window: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q != STOP_NONE |-> hcnt_q == 2'd0)
		else $error("held bytes remain after decoding stopped");

endmodule

/* src/z80rle_queue.sv */
module z80rle_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  z80rle_pkg::pkt_t  push_data,
	output logic              full,
	input  logic              pop,
	output z80rle_pkg::pkt_t  head,
	output logic              empty
);
	import z80rle_pkg::*;

	pkt_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("packet written into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("packet taken from an empty queue");

endmodule

/* src/z80rle_back.sv */
module z80rle_back (
	input  logic              clk,
	input  logic              arst_n,
	input  z80rle_pkg::pkt_t  head,
	input  logic              empty,
	output logic              pop,
	output logic              run_valid,
	input  logic              run_ready,
	output logic [7:0]        out_value,
	output logic [7:0]        repeat_res,
	output logic              run_last,
	output logic [1:0]        stop_status
);
	import z80rle_pkg::*;

	logic [RIDX_W-1:0] idx_q;
	logic              valid_q;
	logic [7:0]        value_q;
	logic [7:0]        rep_q;
	logic              last_q;
	stop_t             status_q;

	logic              load;
	logic              final_run;
	run_t              cur;

	always_comb begin
		load      = !empty && (!valid_q || run_ready);
		cur       = head.runs[idx_q];
		final_run = (idx_q == head.last_idx);
		pop       = load && final_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_run ? '0 : idx_q + RIDX_W'(1);
			end else if (run_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q  <= cur.value;
			rep_q    <= cur.rep;
			last_q   <= final_run && head.blk_last;
			status_q <= (final_run && head.blk_last) ? head.status : STOP_NONE;
		end
	end

	assign run_valid   = valid_q;
	assign out_value   = value_q;
	assign repeat_res  = rep_q;
	assign run_last    = last_q;
	assign stop_status = status_q;

	a_status_on_final_only: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !last_q |-> status_q == STOP_NONE)
		else $error("stop status on a result that is not the last of its block");

	a_empty_run_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && rep_q == 8'd0 |-> last_q)
		else $error("status-only result not marked as last of its block");

endmodule

/* src/z80_snapshot_rle_decoder_unit.sv */
// A byte's results pass from the queue into the output register after its transfer.
// Throughput: one compressed byte per cycle while the queue is not full; a byte that causes
// several results (only the last byte of a block, up to four) holds the output for one output
// transfer per result, while the four-packet queue lets the input keep flowing behind it.
// Reset (arst_n, asynchronous, active low) empties the window, queue and output register
// and sets the output limit to 16384.
module z80_snapshot_rle_decoder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [z80rle_pkg::LIMIT_W-1:0]  cfg_wdata,
	input  logic [7:0]                      data_byte,
	input  logic                            block_last,
	input  logic                            byte_valid,
	output logic                            byte_ready,
	output logic [7:0]                      out_value,
	output logic [7:0]                      repeat_res,
	output logic                            run_last,
	output logic [1:0]                      stop_status,
	output logic                            run_valid,
	input  logic                            run_ready
);
	import z80rle_pkg::*;

	// The output limit register. The user must write it only while the block is idle (the block
	// itself does not enforce this), so the decoder reads it directly without any holding copy.
	logic [LIMIT_W-1:0] limit_q;

	// Packets travel from the decoding front to the serialising back through the queue.
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	pkt_t q_in;
	pkt_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// The front takes one byte per transfer, keeps the three-byte look-ahead window and
	// the produced count, decides the window (literal, run, end marker, zero count or full
	// output limit) and, on the last byte of a block, flushes the held bytes as literals.
	// Everything that one byte causes is written into the queue as a single packet, so
	// the front stalls only when the queue is full.
	z80rle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.block_last (block_last),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.limit      (limit_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_in)
	);

	z80rle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	// The back walks through the descriptors of the packet at the head of the queue,
	// one per output transfer, and marks the final descriptor of a block with the stop
	// status. Its output register is refilled in the same cycle a result is taken, if the queue is not empty.
	z80rle_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.empty       (q_empty),
		.pop         (q_pop),
		.run_valid   (run_valid),
		.run_ready   (run_ready),
		.out_value   (out_value),
		.repeat_res  (repeat_res),
		.run_last    (run_last),
		.stop_status (stop_status)
	);

endmodule
